>>> src/swr_pkg.sv
// ----------------------------------------------------------------------------
// System control register package
// Word kinds, register offsets, reset values and shared types for the
// system control register block with its key-sequence watchdog.
// ----------------------------------------------------------------------------
package swr_pkg;

  // Word kinds on the input stream
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register word offsets
  localparam logic [4:0] ADDR_PLL_STATUS    = 5'h00;
  localparam logic [4:0] ADDR_HIGH_PRESCALE = 5'h09;
  localparam logic [4:0] ADDR_LOW_PRESCALE  = 5'h0A;
  localparam logic [4:0] ADDR_CLK_EN0       = 5'h0B;
  localparam logic [4:0] ADDR_CLK_EN1       = 5'h0C;
  localparam logic [4:0] ADDR_LOW_POWER     = 5'h0D;
  localparam logic [4:0] ADDR_CLK_EN3       = 5'h0F;
  localparam logic [4:0] ADDR_PLL_CONTROL   = 5'h10;
  localparam logic [4:0] ADDR_STATUS_CTRL   = 5'h11;
  localparam logic [4:0] ADDR_WD_COUNT      = 5'h12;
  localparam logic [4:0] ADDR_WD_KEY        = 5'h14;
  localparam logic [4:0] ADDR_WD_CONTROL    = 5'h18;
  localparam logic [4:0] ADDR_MEM_MAP_CFG   = 5'h1D;

  // Reset values
  localparam logic [15:0] RST_PLL_STATUS    = 16'h0001;
  localparam logic [15:0] RST_HIGH_PRESCALE = 16'h0001;
  localparam logic [15:0] RST_LOW_PRESCALE  = 16'h0002;
  localparam logic [15:0] RST_STATUS_CTRL   = 16'h0005;

  // Watchdog key sequence and control bits
  localparam logic [15:0] KEY_FIRST       = 16'h0055;
  localparam logic [15:0] KEY_SECOND      = 16'h00AA;
  localparam int          WD_DISABLE_BIT  = 6;
  localparam int          WD_INT_EN_BIT   = 1;

  localparam int unsigned WAKE_COUNT_DEF  = 512;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic        wake_irq;
    logic        bad_address;
    logic [15:0] read_data;
  } result_t;

endpackage

>>> src/swr_regs.sv
// ----------------------------------------------------------------------------
// System control register file
// Holds the thirteen control registers and the watchdog state, and works
// out the result of one read, write or tick word combinationally.
// ----------------------------------------------------------------------------
module swr_regs #(
  parameter int unsigned WAKE_COUNT = swr_pkg::WAKE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,        // word leaves the input register
  input  logic [1:0]        kind,
  input  logic [4:0]        address,
  input  logic [15:0]       write_data,
  output swr_pkg::result_t  result
);

  localparam logic [15:0] WakeCount = WAKE_COUNT[15:0];

  logic [15:0] pll_status, high_prescale, low_prescale;
  logic [15:0] clock_enable_0, clock_enable_1, low_power_mode, clock_enable_3;
  logic [15:0] pll_control, status_control, memory_map_config;
  logic [15:0] watchdog_count, watchdog_key, watchdog_control;
  logic        watchdog_running;

  logic [15:0] watchdog_count_next;
  logic        watchdog_running_next;
  logic        addr_hit;
  logic [15:0] read_mux;
  logic        wr_en;
  logic        tick_en;

  // Address decode and read mux; the key offset reads back the control reg
  always_comb begin
    addr_hit = 1'b1;
    read_mux = '0;
    case (address)
      swr_pkg::ADDR_PLL_STATUS:    read_mux = pll_status;
      swr_pkg::ADDR_HIGH_PRESCALE: read_mux = high_prescale;
      swr_pkg::ADDR_LOW_PRESCALE:  read_mux = low_prescale;
      swr_pkg::ADDR_CLK_EN0:       read_mux = clock_enable_0;
      swr_pkg::ADDR_CLK_EN1:       read_mux = clock_enable_1;
      swr_pkg::ADDR_LOW_POWER:     read_mux = low_power_mode;
      swr_pkg::ADDR_CLK_EN3:       read_mux = clock_enable_3;
      swr_pkg::ADDR_PLL_CONTROL:   read_mux = pll_control;
      swr_pkg::ADDR_STATUS_CTRL:   read_mux = status_control;
      swr_pkg::ADDR_WD_COUNT:      read_mux = watchdog_count;
      swr_pkg::ADDR_WD_KEY:        read_mux = watchdog_control;
      swr_pkg::ADDR_WD_CONTROL:    read_mux = watchdog_control;
      swr_pkg::ADDR_MEM_MAP_CFG:   read_mux = memory_map_config;
      default:                     addr_hit = 1'b0;
    endcase
  end

  assign wr_en   = fire && (kind == swr_pkg::KIND_WRITE) && addr_hit;
  assign tick_en = fire && (kind == swr_pkg::KIND_TICK) && watchdog_running;

  // Watchdog counter and run flag
  always_comb begin
    watchdog_count_next   = watchdog_count;
    watchdog_running_next = watchdog_running;
    if (wr_en) begin
      if (address == swr_pkg::ADDR_WD_COUNT) begin
        watchdog_count_next = write_data;
      end else if (address == swr_pkg::ADDR_WD_KEY) begin
        if (watchdog_key == swr_pkg::KEY_FIRST && write_data == swr_pkg::KEY_SECOND) begin
          watchdog_count_next = '0;
        end
      end else if (address == swr_pkg::ADDR_WD_CONTROL) begin
        watchdog_running_next = 1'b1;
      end
    end else if (tick_en && !watchdog_control[swr_pkg::WD_DISABLE_BIT]) begin
      watchdog_count_next = watchdog_count + 16'd1;
    end
  end

  // Result word
  always_comb begin
    result = '0;
    unique case (kind)
      swr_pkg::KIND_READ: begin
        result.read_data   = addr_hit ? read_mux : '0;
        result.bad_address = !addr_hit;
      end
      swr_pkg::KIND_WRITE: begin
        result.bad_address = !addr_hit;
      end
      swr_pkg::KIND_TICK: begin
        result.wake_irq = watchdog_running && (watchdog_count_next == WakeCount) &&
                          status_control[swr_pkg::WD_INT_EN_BIT];
      end
      default: result = '0;
    endcase
  end

  // Register storage
  always_ff @(posedge clk) begin
    if (rst) begin
      pll_status        <= swr_pkg::RST_PLL_STATUS;
      high_prescale     <= swr_pkg::RST_HIGH_PRESCALE;
      low_prescale      <= swr_pkg::RST_LOW_PRESCALE;
      clock_enable_0    <= '0;
      clock_enable_1    <= '0;
      low_power_mode    <= '0;
      clock_enable_3    <= '0;
      pll_control       <= '0;
      status_control    <= swr_pkg::RST_STATUS_CTRL;
      watchdog_key      <= '0;
      watchdog_control  <= '0;
      memory_map_config <= '0;
      watchdog_count    <= '0;
      watchdog_running  <= 1'b0;
    end else begin
      watchdog_count   <= watchdog_count_next;
      watchdog_running <= watchdog_running_next;
      if (wr_en) begin
        case (address)
          swr_pkg::ADDR_PLL_STATUS:    pll_status        <= write_data;
          swr_pkg::ADDR_HIGH_PRESCALE: high_prescale     <= write_data;
          swr_pkg::ADDR_LOW_PRESCALE:  low_prescale      <= write_data;
          swr_pkg::ADDR_CLK_EN0:       clock_enable_0    <= write_data;
          swr_pkg::ADDR_CLK_EN1:       clock_enable_1    <= write_data;
          swr_pkg::ADDR_LOW_POWER:     low_power_mode    <= write_data;
          swr_pkg::ADDR_CLK_EN3:       clock_enable_3    <= write_data;
          swr_pkg::ADDR_PLL_CONTROL:   pll_control       <= write_data;
          swr_pkg::ADDR_STATUS_CTRL:   status_control    <= write_data;
          swr_pkg::ADDR_WD_KEY:        watchdog_key      <= write_data;
          swr_pkg::ADDR_WD_CONTROL:    watchdog_control  <= write_data;
          swr_pkg::ADDR_MEM_MAP_CFG:   memory_map_config <= write_data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // Watchdog starts on a control register write
  a_run_on_ctrl_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && address == swr_pkg::ADDR_WD_CONTROL) |=> watchdog_running)
    else $error("watchdog not running after control write");

  // Enabled tick advances the counter by one
  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    (tick_en && !watchdog_control[swr_pkg::WD_DISABLE_BIT])
    |=> watchdog_count == $past(watchdog_count) + 16'd1)
    else $error("tick did not advance watchdog counter");

  // Reads leave the counter alone
  a_read_holds_count: assert property (@(posedge clk) disable iff (rst)
    (fire && kind == swr_pkg::KIND_READ) |=> $stable(watchdog_count))
    else $error("read changed watchdog counter");

  // Interrupt only on a tick from a running watchdog
  a_irq_on_tick: assert property (@(posedge clk) disable iff (rst)
    result.wake_irq |-> (kind == swr_pkg::KIND_TICK && watchdog_running &&
                         !result.bad_address))
    else $error("wake interrupt outside a running tick");
`endif

endmodule

>>> src/system_control_watchdog_registers.sv
// Path: input register, then the register file, then the output register (two register stages).
// Throughput: one word per cycle while the sink is ready; the register-file update is combinational between stages.
// Reset: rst (synchronous, active high) empties both stages and loads register reset values.
// ----------------------------------------------------------------------------
// System control registers with watchdog
// Stream front end: an input register feeds the register file, whose
// result goes to an output register held until the sink takes it.
// ----------------------------------------------------------------------------
module system_control_watchdog_registers #(
  parameter int unsigned WAKE_COUNT = swr_pkg::WAKE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [4:0] address, [20:5] write_data
  input  logic [1:0]                      s_tuser,   // [1:0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swr_pkg::OUT_TDATA_W-1:0] m_tdata    // [15:0] read_data, [16] bad_address,
                                                     // [17] wake_irq
);

  logic              in_valid;
  logic [1:0]        in_kind;
  logic [4:0]        in_address;
  logic [15:0]       in_write_data;
  logic              out_valid;
  swr_pkg::result_t  out_result;
  swr_pkg::result_t  result;
  logic              advance;

  // Move a word on when the output register is free or being emptied
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind       <= s_tuser;
      in_address    <= s_tdata[4:0];
      in_write_data <= s_tdata[20:5];
    end
  end

  swr_regs #(
    .WAKE_COUNT(WAKE_COUNT)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .kind      (in_kind),
    .address   (in_address),
    .write_data(in_write_data),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(swr_pkg::OUT_TDATA_W - 18){1'b0}}, out_result};

endmodule
